@@ rtl/jopa_pkg.sv @@
// Shared types and constants for the opcode allow-list predecoder.
// No dependencies.
`default_nettype none

package jopa_pkg;

   // Opcode group selectors (bits 15..12)
   localparam logic [3:0] GRP_MOVE_B  = 4'h1;
   localparam logic [3:0] GRP_MOVE_L  = 4'h2;
   localparam logic [3:0] GRP_MOVE_W  = 4'h3;
   localparam logic [3:0] GRP_MISC    = 4'h4;
   localparam logic [3:0] GRP_BRANCH  = 4'h6;
   localparam logic [3:0] GRP_MOVEQ   = 4'h7;
   localparam logic [3:0] GRP_OR      = 4'h8;
   localparam logic [3:0] GRP_SUB     = 4'h9;
   localparam logic [3:0] GRP_CMP     = 4'hB;
   localparam logic [3:0] GRP_AND     = 4'hC;
   localparam logic [3:0] GRP_ADD     = 4'hD;

   // LEA match
   localparam logic [15:0] LEA_MASK  = 16'hF1C0;
   localparam logic [15:0] LEA_MATCH = 16'h41C0;

   // Selectors inside the misc group
   localparam logic [3:0] MISC_SEL_TST = 4'hA;
   localparam logic [3:0] MISC_SEL_CLR = 4'h2;

   // Effective address modes
   localparam logic [2:0] EA_DREG     = 3'd0;
   localparam logic [2:0] EA_AREG     = 3'd1;
   localparam logic [2:0] EA_IND      = 3'd2;
   localparam logic [2:0] EA_DISP     = 3'd5;
   localparam logic [2:0] EA_SPECIAL  = 3'd7;
   localparam logic [2:0] EA_REG_IMM  = 3'd4;
   localparam logic [2:0] EA_REG_ABSL = 3'd1;

   // Size field value with no meaning for tst/clr
   localparam logic [1:0] SIZE_NONE = 2'd3;

   // Branch special cases
   localparam logic [3:0] COND_SUBR  = 4'h1;
   localparam logic [7:0] DISP_WORD  = 8'h00;
   localparam logic [7:0] DISP_LONG  = 8'hFF;
   localparam logic [9:0] PC_STEP    = 10'd2;

   // Operation kinds
   localparam logic [3:0] KIND_MOVE_DD   = 4'd0;
   localparam logic [3:0] KIND_MOVE_AD   = 4'd1;
   localparam logic [3:0] KIND_MOVE_ID   = 4'd2;
   localparam logic [3:0] KIND_MOVEA_DA  = 4'd3;
   localparam logic [3:0] KIND_MOVEA_AA  = 4'd4;
   localparam logic [3:0] KIND_MOVEA_IA  = 4'd5;
   localparam logic [3:0] KIND_LEA_DISP  = 4'd6;
   localparam logic [3:0] KIND_LEA_ABS   = 4'd7;
   localparam logic [3:0] KIND_TST       = 4'd8;
   localparam logic [3:0] KIND_CLR       = 4'd9;
   localparam logic [3:0] KIND_MOVEQ     = 4'd10;
   localparam logic [3:0] KIND_ALU       = 4'd11;
   localparam logic [3:0] KIND_BRANCH    = 4'd12;

   // ALU operations
   localparam logic [2:0] ALU_ADD = 3'd0;
   localparam logic [2:0] ALU_SUB = 3'd1;
   localparam logic [2:0] ALU_CMP = 3'd2;
   localparam logic [2:0] ALU_AND = 3'd3;
   localparam logic [2:0] ALU_OR  = 3'd4;

   // Cycle charges
   localparam logic [3:0] CYC_BASE        = 4'd4;
   localparam logic [3:0] CYC_CLR         = 4'd6;
   localparam logic [3:0] CYC_BRANCH_BYTE = 4'd8;
   localparam logic [3:0] CYC_BRANCH_WORD = 4'd12;

   // Operand sizes in bytes
   localparam logic [2:0] BYTES_NONE = 3'd0;
   localparam logic [2:0] BYTES_1    = 3'd1;
   localparam logic [2:0] BYTES_2    = 3'd2;
   localparam logic [2:0] BYTES_4    = 3'd4;

   typedef struct packed {
      logic        accepted;
      logic [3:0]  op_kind;
      logic [2:0]  alu_kind;
      logic [2:0]  source_reg;
      logic [2:0]  dest_reg;
      logic [2:0]  operand_bytes;
      logic [3:0]  base_cycles;
      logic [31:0] immediate;
      logic [3:0]  condition;
   } result_type;

   // 2-bit size field (0 byte, 1 word, 2 long) to bytes
   function automatic logic [2:0] size_bytes(input logic [1:0] sf);
      logic [2:0] b;
      case (sf)
         2'd0:    b = BYTES_1;
         2'd1:    b = BYTES_2;
         default: b = BYTES_4;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

@@ rtl/jopa_if.sv @@
// Valid/ready channel interfaces for request and response items.
// No dependencies; field widths match jopa_pkg::result_type.
`default_nettype none

interface jopa_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] opcode;
   logic [31:0] instr_addr;

   modport source (output valid, output opcode, output instr_addr, input ready);
   modport sink   (input valid, input opcode, input instr_addr, output ready);
endinterface

interface jopa_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [3:0]  op_kind;
   logic [2:0]  alu_kind;
   logic [2:0]  source_reg;
   logic [2:0]  dest_reg;
   logic [2:0]  operand_bytes;
   logic [3:0]  base_cycles;
   logic [31:0] immediate;
   logic [3:0]  condition;

   modport source (output valid, output accepted, output op_kind, output alu_kind,
                   output source_reg, output dest_reg, output operand_bytes,
                   output base_cycles, output immediate, output condition,
                   input ready);
   modport sink   (input valid, input accepted, input op_kind, input alu_kind,
                   input source_reg, input dest_reg, input operand_bytes,
                   input base_cycles, input immediate, input condition,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/jopa_decode.sv @@
// Combinational classifier for one instruction word.
// Depends on jopa_pkg.
`default_nettype none

module jopa_decode (
   input  wire logic [15:0]           opcode,
   input  wire logic [31:0]           instr_addr,
   output jopa_pkg::result_type       result
);
   import jopa_pkg::*;

   logic [3:0] grp;
   logic [2:0] smode, sreg, dmode, dreg;
   logic [1:0] sf;
   logic [3:0] sel;
   logic [7:0] disp;
   logic [9:0] br_offset;
   logic [31:0] br_target;
   logic [2:0] move_bytes;
   logic       move_imm;
   logic       lea_disp, lea_abs;
   logic       ok;
   result_type d;

   assign grp   = opcode[15:12];
   assign dreg  = opcode[11:9];
   assign dmode = opcode[8:6];
   assign smode = opcode[5:3];
   assign sreg  = opcode[2:0];
   assign sf    = opcode[7:6];
   assign sel   = opcode[11:8];
   assign disp  = opcode[7:0];

   assign move_imm = (smode == EA_SPECIAL) && (sreg == EA_REG_IMM);
   assign lea_disp = (smode == EA_IND) || (smode == EA_DISP);
   assign lea_abs  = (smode == EA_SPECIAL) && (sreg <= EA_REG_ABSL);

   // Word branch: target base is pc+2; short branch adds the signed byte too
   assign br_offset = (disp == DISP_WORD) ? PC_STEP
                                          : ({{2{disp[7]}}, disp} + PC_STEP);
   assign br_target = instr_addr + {{22{br_offset[9]}}, br_offset};

   always_comb begin
      case (grp)
         GRP_MOVE_B: move_bytes = BYTES_1;
         GRP_MOVE_L: move_bytes = BYTES_4;
         default:    move_bytes = BYTES_2;
      endcase
   end

   always_comb begin
      d  = '0;
      ok = 1'b0;
      case (grp)
         GRP_MOVE_B, GRP_MOVE_L, GRP_MOVE_W: begin
            ok = (dmode <= EA_AREG) && (smode <= EA_AREG || move_imm) &&
                 !(move_bytes == BYTES_1 && (smode == EA_AREG || dmode == EA_AREG));
            if (dmode == EA_AREG) begin
               d.op_kind = move_imm ? KIND_MOVEA_IA :
                           (smode == EA_AREG) ? KIND_MOVEA_AA : KIND_MOVEA_DA;
            end else begin
               d.op_kind = move_imm ? KIND_MOVE_ID :
                           (smode == EA_AREG) ? KIND_MOVE_AD : KIND_MOVE_DD;
            end
            d.source_reg    = sreg;
            d.dest_reg      = dreg;
            d.operand_bytes = move_bytes;
            d.base_cycles   = CYC_BASE;
         end
         GRP_MISC: begin
            if ((opcode & LEA_MASK) == LEA_MATCH) begin
               ok              = lea_disp || lea_abs;
               d.op_kind       = lea_disp ? KIND_LEA_DISP : KIND_LEA_ABS;
               d.source_reg    = sreg;
               d.dest_reg      = dreg;
               d.operand_bytes = BYTES_4;
               d.base_cycles   = CYC_BASE;
            end else if (sf != SIZE_NONE && smode == EA_DREG) begin
               d.operand_bytes = size_bytes(sf);
               if (sel == MISC_SEL_TST) begin
                  ok            = 1'b1;
                  d.op_kind     = KIND_TST;
                  d.source_reg  = sreg;
                  d.base_cycles = CYC_BASE;
               end else if (sel == MISC_SEL_CLR) begin
                  ok            = 1'b1;
                  d.op_kind     = KIND_CLR;
                  d.dest_reg    = sreg;
                  d.base_cycles = CYC_CLR;
               end
            end
         end
         GRP_BRANCH: begin
            ok          = (sel != COND_SUBR) && (disp != DISP_LONG);
            d.op_kind   = KIND_BRANCH;
            d.condition = sel;
            d.immediate = br_target;
            d.base_cycles = (disp == DISP_WORD) ? CYC_BRANCH_WORD : CYC_BRANCH_BYTE;
         end
         GRP_MOVEQ: begin
            ok              = !opcode[8];
            d.op_kind       = KIND_MOVEQ;
            d.dest_reg      = dreg;
            d.operand_bytes = BYTES_4;
            d.immediate     = {{24{disp[7]}}, disp};
            d.base_cycles   = CYC_BASE;
         end
         GRP_OR, GRP_SUB, GRP_CMP, GRP_AND, GRP_ADD: begin
            // register form only: Dn source, opmode 0..2
            ok = !dmode[2] && (dmode[1:0] != 2'd3) && (smode == EA_DREG);
            case (grp)
               GRP_OR:  d.alu_kind = ALU_OR;
               GRP_SUB: d.alu_kind = ALU_SUB;
               GRP_CMP: d.alu_kind = ALU_CMP;
               GRP_AND: d.alu_kind = ALU_AND;
               default: d.alu_kind = ALU_ADD;
            endcase
            d.op_kind       = KIND_ALU;
            d.source_reg    = sreg;
            d.dest_reg      = dreg;
            d.operand_bytes = size_bytes(dmode[1:0]);
            d.base_cycles   = CYC_BASE;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      if (ok) begin
         result          = d;
         result.accepted = 1'b1;
      end else begin
         result = '0;
      end
   end

endmodule

`default_nettype wire

@@ rtl/jit_opcode_allowlist_predecoder.sv @@
// Top level of the opcode allow-list predecoder: input register, decoder, result register.
// Depends on jopa_pkg, jopa_if and jopa_decode.
`default_nettype none

// One instruction word and its address go in per item; exactly one result item
// comes out, in order. The block sustains one item per clock while the response
// channel takes results: a word is captured in the input register, classified by
// a single pass of combinational decode (one 32-bit add for the branch target is
// the longest path), and the result is held in the result register until taken.
// A request passes through the input register and then the result register
// before its result shows on the response channel. Both stages advance
// whenever the stage ahead is empty or being drained, so a stalled response
// still leaves room for one more request. A word off the allow-list gives a
// result with every field zero. No configuration, no state between items.

module jit_opcode_allowlist_predecoder (
   input wire logic  clock,
   input wire logic  reset,
   jopa_req_if.sink   req_chan,
   jopa_rsp_if.source rsp_chan
);
   import jopa_pkg::*;

   // input register stage
   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_opcode_ff;
   logic [31:0] in_addr_ff;
   logic        in_ready;

   // result register stage
   logic        out_valid_ff, out_valid_in;
   result_type  out_result_ff;
   logic        out_ready;

   result_type  decoded;

   // a stage can take a new item when empty or when its item leaves this cycle
   assign out_ready = !out_valid_ff || rsp_chan.ready;
   assign in_ready  = !in_valid_ff || out_ready;

   assign req_chan.ready = in_ready;

   assign in_valid_in  = req_chan.valid || (in_valid_ff && !out_ready);
   assign out_valid_in = (in_valid_ff && out_ready) || (out_valid_ff && !rsp_chan.ready);

   jopa_decode u_decode (
      .opcode     (in_opcode_ff),
      .instr_addr (in_addr_ff),
      .result     (decoded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_chan.valid && in_ready) begin
         in_opcode_ff <= req_chan.opcode;
         in_addr_ff   <= req_chan.instr_addr;
      end
      if (in_valid_ff && out_ready) begin
         out_result_ff <= decoded;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.accepted      = out_result_ff.accepted;
   assign rsp_chan.op_kind       = out_result_ff.op_kind;
   assign rsp_chan.alu_kind      = out_result_ff.alu_kind;
   assign rsp_chan.source_reg    = out_result_ff.source_reg;
   assign rsp_chan.dest_reg      = out_result_ff.dest_reg;
   assign rsp_chan.operand_bytes = out_result_ff.operand_bytes;
   assign rsp_chan.base_cycles   = out_result_ff.base_cycles;
   assign rsp_chan.immediate     = out_result_ff.immediate;
   assign rsp_chan.condition     = out_result_ff.condition;

endmodule

`default_nettype wire

@@ tb/jit_opcode_allowlist_predecoder_tb.sv @@
// Testbench for the opcode allow-list predecoder: a directed table, then random words.
// Results are checked field by field against typed rows or the in-file decoder model.
// Depends on jopa_pkg, jopa_if and the jit_opcode_allowlist_predecoder RTL.
`timescale 1ns / 1ps

module jit_opcode_allowlist_predecoder_tb;
   import jopa_pkg::*;

   // No item moves on either channel for this many cycles -> hang.
   localparam int STALL_LIMIT  = 2000;
   // Extra cycles to settle at the end, after the last result is taken.
   localparam int DRAIN_CYCLES = 10;
   localparam int N_RANDOM     = 1250;
   localparam int N_DIRECTED   = 28;

   // Condition 0 is the unconditional branch; also the value when not a branch.
   localparam logic [3:0] COND_ALWAYS = 4'h0;
   localparam logic [2:0] NO_ALU      = 3'd0;
   localparam logic [2:0] NO_REG      = 3'd0;

   localparam result_type REJECTED = '0;
   localparam logic TYPED     = 1'b1;   // row carries its own expected result
   localparam logic PREDICTED = 1'b0;   // row is checked against the decoder model

   typedef struct packed {
      logic [15:0] word;
      logic [31:0] pc;
      logic        typed;
      result_type  want;
   } dir_row_type;

   // One instruction word in flight and the decode it must produce.
   typedef struct {
      logic [15:0] word;
      logic [31:0] pc;
      result_type  want;
   } pending_decode_type;

   // Directed words: a form of every kind, every ALU op, and the
   // rejects (byte size with an address register, size field 3, moveq bit 8,
   // ALU opmode 3 and memory direction, subroutine call, long displacement).
   localparam dir_row_type DIR_ROWS [N_DIRECTED] = '{
      '{16'h0000, 32'h0000_0000, TYPED,     REJECTED},           // all zero
      '{16'hFFFF, 32'hFFFF_FFFF, TYPED,     REJECTED},           // all ones
      '{16'h1001, 32'h0000_1000, PREDICTED, REJECTED},           // move.b d1,d0
      '{16'h2E09, 32'h0000_1002, PREDICTED, REJECTED},           // move.l a1,d7
      '{16'h303C, 32'h0000_1004, PREDICTED, REJECTED},           // move.w #imm,d0
      '{16'h2240, 32'h0000_1006, PREDICTED, REJECTED},           // movea.l d0,a1
      '{16'h3E4F, 32'h0000_1008, PREDICTED, REJECTED},           // movea.w a7,a7
      '{16'h207C, 32'h0000_100A, PREDICTED, REJECTED},           // movea.l #imm,a0
      '{16'h1240, 32'h0000_100C, TYPED,     REJECTED},           // move.b to An
      '{16'h1009, 32'h0000_100E, TYPED,     REJECTED},           // move.b from An
      '{16'h41D0, 32'h0000_1010, PREDICTED, REJECTED},           // lea (a0),a0
      '{16'h4FF9, 32'h0000_1012, PREDICTED, REJECTED},           // lea abs.l,a7
      '{16'h4A87, 32'h0000_1014, PREDICTED, REJECTED},           // tst.l d7
      '{16'h4200, 32'h0000_1016, PREDICTED, REJECTED},           // clr.b d0
      '{16'h4AC0, 32'h0000_1018, TYPED,     REJECTED},           // tst, size field 3
      '{16'h70FF, 32'h0000_101A, TYPED,
        '{1'b1, KIND_MOVEQ, NO_ALU, NO_REG, NO_REG, BYTES_4, CYC_BASE,
          32'hFFFF_FFFF, COND_ALWAYS}},                         // moveq #-1,d0
      '{16'h7100, 32'h0000_101C, TYPED,     REJECTED},           // moveq, bit 8 set
      '{16'hD041, 32'h0000_101E, PREDICTED, REJECTED},           // add.w d1,d0
      '{16'h9000, 32'h0000_1020, PREDICTED, REJECTED},           // sub.b d0,d0
      '{16'hB240, 32'h0000_1022, PREDICTED, REJECTED},           // cmp.w d0,d1
      '{16'hC400, 32'h0000_1024, PREDICTED, REJECTED},           // and.b d0,d2
      '{16'h8E82, 32'h0000_1026, PREDICTED, REJECTED},           // or.l d2,d7
      '{16'hB0C0, 32'h0000_1028, TYPED,     REJECTED},           // opmode 3 (address form)
      '{16'hD101, 32'h0000_102A, TYPED,     REJECTED},           // memory direction
      '{16'h6000, 32'hFFFF_FFFE, TYPED,
        '{1'b1, KIND_BRANCH, NO_ALU, NO_REG, NO_REG, BYTES_NONE, CYC_BRANCH_WORD,
          32'h0000_0000, COND_ALWAYS}},                         // bra.w, base wraps to 0
      '{16'h6780, 32'h0000_0000, PREDICTED, REJECTED},           // beq.s -128 from 0
      '{16'h6102, 32'h0000_2000, TYPED,     REJECTED},           // subroutine call
      '{16'h60FF, 32'h0000_2000, TYPED,     REJECTED}            // long displacement
   };

   logic clock;
   logic reset;
   logic calm;   // stretch with no idling on either side

   jopa_req_if req_chan ();
   jopa_rsp_if rsp_chan ();

   jit_opcode_allowlist_predecoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pending_decode_type pending_decodes [$];
   int unsigned     mismatches   = 0;
   int unsigned     words_sent;
   int unsigned     words_listed = 0;
   int unsigned     results_seen = 0;
   int unsigned     idle_cycles;
   int unsigned     stall_left;
   logic [15:0]     kinds_seen   = '0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // 2-bit size field: 0 byte, 1 word, else long.
   function automatic logic [2:0] field_to_bytes(input logic [1:0] sf);
      case (sf)
         2'd0:    return BYTES_1;
         2'd1:    return BYTES_2;
         default: return BYTES_4;
      endcase
   endfunction

   // Decoder model: classify one word at pc; anything off the list is all zero.
   function automatic result_type predict_decode(input logic [15:0] op, input logic [31:0] pc);
      result_type r;
      logic       ok;
      logic       from_imm;
      logic [3:0] grp;
      logic [2:0] mode, rlo, dmode, opm;
      logic [7:0] disp;
      r        = '0;
      ok       = 1'b0;
      grp      = op[15:12];
      mode     = op[5:3];
      rlo      = op[2:0];
      dmode    = op[8:6];
      opm      = op[8:6];
      disp     = op[7:0];
      from_imm = (mode == EA_SPECIAL) && (rlo == EA_REG_IMM);
      case (grp)
         GRP_MOVE_B, GRP_MOVE_L, GRP_MOVE_W: begin
            r.operand_bytes = (grp == GRP_MOVE_B) ? BYTES_1 :
                              (grp == GRP_MOVE_L) ? BYTES_4 : BYTES_2;
            // registers or immediate only; byte moves never touch An
            if (dmode <= EA_AREG && (mode <= EA_AREG || from_imm) &&
                !(r.operand_bytes == BYTES_1 && (mode == EA_AREG || dmode == EA_AREG))) begin
               ok = 1'b1;
               if (dmode == EA_AREG)
                  r.op_kind = from_imm ? KIND_MOVEA_IA :
                              (mode == EA_AREG) ? KIND_MOVEA_AA : KIND_MOVEA_DA;
               else
                  r.op_kind = from_imm ? KIND_MOVE_ID :
                              (mode == EA_AREG) ? KIND_MOVE_AD : KIND_MOVE_DD;
               r.source_reg  = rlo;
               r.dest_reg    = op[11:9];
               r.base_cycles = CYC_BASE;
            end
         end
         GRP_MISC: begin
            if ((op & LEA_MASK) == LEA_MATCH) begin
               if (mode == EA_IND || mode == EA_DISP ||
                   (mode == EA_SPECIAL && rlo <= EA_REG_ABSL)) begin
                  ok            = 1'b1;
                  r.op_kind     = (mode == EA_SPECIAL) ? KIND_LEA_ABS : KIND_LEA_DISP;
                  r.source_reg  = rlo;
                  r.dest_reg    = op[11:9];
                  r.operand_bytes = BYTES_4;
                  r.base_cycles = CYC_BASE;
               end
            end else if (op[7:6] != SIZE_NONE && mode == EA_DREG) begin
               r.operand_bytes = field_to_bytes(op[7:6]);
               if (op[11:8] == MISC_SEL_TST) begin
                  ok            = 1'b1;
                  r.op_kind     = KIND_TST;
                  r.source_reg  = rlo;
                  r.base_cycles = CYC_BASE;
               end else if (op[11:8] == MISC_SEL_CLR) begin
                  ok            = 1'b1;
                  r.op_kind     = KIND_CLR;
                  r.dest_reg    = rlo;
                  r.base_cycles = CYC_CLR;
               end
            end
         end
         GRP_BRANCH: begin
            if (op[11:8] != COND_SUBR && disp != DISP_LONG) begin
               ok          = 1'b1;
               r.op_kind   = KIND_BRANCH;
               r.condition = op[11:8];
               if (disp == DISP_WORD) begin
                  r.base_cycles = CYC_BRANCH_WORD;
                  r.immediate   = pc + 32'(PC_STEP);
               end else begin
                  r.base_cycles = CYC_BRANCH_BYTE;
                  r.immediate   = pc + 32'(PC_STEP) + {{24{disp[7]}}, disp};
               end
            end
         end
         GRP_MOVEQ: begin
            if (!op[8]) begin
               ok              = 1'b1;
               r.op_kind       = KIND_MOVEQ;
               r.dest_reg      = op[11:9];
               r.operand_bytes = BYTES_4;
               r.base_cycles   = CYC_BASE;
               r.immediate     = {{24{disp[7]}}, disp};
            end
         end
         GRP_OR, GRP_SUB, GRP_CMP, GRP_AND, GRP_ADD: begin
            // Dn,Dn with the register as destination: opmode 0..2 only
            if (!opm[2] && opm[1:0] != 2'd3 && mode == EA_DREG) begin
               ok = 1'b1;
               case (grp)
                  GRP_OR:  r.alu_kind = ALU_OR;
                  GRP_SUB: r.alu_kind = ALU_SUB;
                  GRP_CMP: r.alu_kind = ALU_CMP;
                  GRP_AND: r.alu_kind = ALU_AND;
                  default: r.alu_kind = ALU_ADD;
               endcase
               r.op_kind       = KIND_ALU;
               r.source_reg    = rlo;
               r.dest_reg      = op[11:9];
               r.operand_bytes = field_to_bytes(opm[1:0]);
               r.base_cycles   = CYC_BASE;
            end
         end
         default: ok = 1'b0;
      endcase
      if (ok) r.accepted = 1'b1;
      else r = '0;
      return r;
   endfunction

   // Offer one word, hold it until taken, queue its decode, then maybe idle.
   task automatic send_word(input logic [15:0] op, input logic [31:0] pc,
                            input result_type want);
      int gap;
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= op;
      req_chan.instr_addr <= pc;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_decodes.push_back('{op, pc, want});
      words_sent++;
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic check_field(input pending_decode_type entry, input string name,
                              input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: word 0x%04h at 0x%08h: %s expected 0x%0h, got 0x%0h",
                  $time, entry.word, entry.pc, name, want, got);
      end
   endtask

   // Stimulus: reset, directed rows, then random words.
   initial begin
      reset               = 1'b1;
      calm                = 1'b0;
      req_chan.valid      = 1'b0;
      req_chan.opcode     = 16'h0000;
      req_chan.instr_addr = 32'h0000_0000;
      words_sent          = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_word(DIR_ROWS[i].word, DIR_ROWS[i].pc,
                   DIR_ROWS[i].typed ? DIR_ROWS[i].want
                                     : predict_decode(DIR_ROWS[i].word, DIR_ROWS[i].pc));
      end

      // Random words: most are shaped into one of the listed families with
      // random fields (and a few bad fields), the rest are raw noise.
      for (int n = 0; n < N_RANDOM; n++) begin : rand_word
         logic [15:0] w;
         logic [31:0] pc;
         logic [3:0]  grp;
         logic [2:0]  ra, rb, ma, mb;
         logic [7:0]  disp;
         int          pick;
         if (n % 50 == 0) calm <= ($urandom_range(0, 3) == 0);
         w    = 16'($urandom);
         ra   = 3'($urandom);
         rb   = 3'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 22) begin
            // move / movea
            grp = 4'($urandom_range(1, 3));
            ma  = ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
               0:       mb = 3'($urandom);
               1: begin
                  mb = EA_SPECIAL;
                  rb = EA_REG_IMM;
               end
               default: mb = 3'($urandom_range(0, 1));
            endcase
            w = {grp, ra, ma, mb, rb};
         end else if (pick < 32) begin
            // lea with every ea mode, absolute short/long near the edge
            case ($urandom_range(0, 3))
               0:       mb = EA_IND;
               1:       mb = EA_DISP;
               2: begin
                  mb = EA_SPECIAL;
                  rb = 3'($urandom_range(0, 2));
               end
               default: mb = 3'($urandom);
            endcase
            w = LEA_MATCH | {4'h0, ra, 9'h000} | {10'h000, mb, rb};
         end else if (pick < 44) begin
            // tst / clr, all size fields, mostly Dn
            mb = ($urandom_range(0, 4) == 0) ? 3'($urandom) : EA_DREG;
            w  = {GRP_MISC, ($urandom_range(0, 1) != 0) ? MISC_SEL_TST : MISC_SEL_CLR,
                  2'($urandom), mb, rb};
         end else if (pick < 54) begin
            w = {GRP_MOVEQ, ra, ($urandom_range(0, 7) == 0), 8'($urandom)};
         end else if (pick < 76) begin
            case ($urandom_range(0, 4))
               0:       grp = GRP_OR;
               1:       grp = GRP_SUB;
               2:       grp = GRP_CMP;
               3:       grp = GRP_AND;
               default: grp = GRP_ADD;
            endcase
            ma = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
            mb = ($urandom_range(0, 5) == 0) ? 3'($urandom) : EA_DREG;
            w  = {grp, ra, ma, mb, rb};
         end else if (pick < 92) begin
            case ($urandom_range(0, 7))
               0:       disp = DISP_WORD;
               1:       disp = DISP_LONG;
               default: disp = 8'($urandom);
            endcase
            w = {GRP_BRANCH, 4'($urandom), disp};
         end
         // addresses near both ends exercise the target wrap
         case ($urandom_range(0, 7))
            0:       pc = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
            1:       pc = 32'($urandom_range(0, 255));
            default: pc = $urandom;
         endcase
         send_word(w, pc, predict_decode(w, pc));
      end

      req_chan.valid <= 1'b0;
      calm           <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d words (%0d directed, %0d random); %0d results, %0d on the list",
               words_sent, N_DIRECTED, words_sent - N_DIRECTED, results_seen, words_listed);
      $display("op kinds seen: mask 0x%04h; field mismatches: %0d", kinds_seen, mismatches);
      if (mismatches == 0 && pending_decodes.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Result side: random back-pressure, with calm stretches.
   always @(posedge clock) begin
      if (reset) begin
         stall_left     <= 0;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left     <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         stall_left     <= pick_gap();
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Compare each taken result with the oldest outstanding decode.
   always @(posedge clock) begin
      result_type      got;
      pending_decode_type entry;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.accepted      = rsp_chan.accepted;
         got.op_kind       = rsp_chan.op_kind;
         got.alu_kind      = rsp_chan.alu_kind;
         got.source_reg    = rsp_chan.source_reg;
         got.dest_reg      = rsp_chan.dest_reg;
         got.operand_bytes = rsp_chan.operand_bytes;
         got.base_cycles   = rsp_chan.base_cycles;
         got.immediate     = rsp_chan.immediate;
         got.condition     = rsp_chan.condition;
         results_seen++;
         if (pending_decodes.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing outstanding: expected none, got 0x%0h",
                     $time, got);
         end else begin
            entry = pending_decodes.pop_front();
            check_field(entry, "accepted",      entry.want.accepted,      got.accepted);
            check_field(entry, "op_kind",       entry.want.op_kind,       got.op_kind);
            check_field(entry, "alu_kind",      entry.want.alu_kind,      got.alu_kind);
            check_field(entry, "source_reg",    entry.want.source_reg,    got.source_reg);
            check_field(entry, "dest_reg",      entry.want.dest_reg,      got.dest_reg);
            check_field(entry, "operand_bytes", entry.want.operand_bytes, got.operand_bytes);
            check_field(entry, "base_cycles",   entry.want.base_cycles,   got.base_cycles);
            check_field(entry, "immediate",     entry.want.immediate,     got.immediate);
            check_field(entry, "condition",     entry.want.condition,     got.condition);
            if (entry.want.accepted) begin
               words_listed++;
               kinds_seen[entry.want.op_kind] = 1'b1;
            end
         end
      end
   end

   // Watchdog: ends the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, pending_decodes.size());
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
